/* rtl/core/bst_pkg.sv */
`default_nettype none
package bst_pkg;

    // Table geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Word field widths
    localparam int CMD_W = 2;
    localparam int VAL_W = 32;
    localparam int RIX_W = 4;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MEMBER = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Control shared by every cell of the ring
    typedef struct packed {
        logic shift;   // rotate the ring by one place
        logic wr_en;   // write the selected cell
    } t_cell_ctl;

endpackage
`default_nettype wire

/* rtl/core/bounded_set_table_unit.sv */
`default_nettype none
// Channel   Direction  Handshake            Payload
// command   in         i_valid / o_ready    i_command, i_value, i_index
// result    out        o_valid / i_ready    o_success, o_read_value, o_index_error,
//                                           o_entry_count
// config    in         i_cfg_we             i_cfg_data (capacity limit)
//
// Every word is latched, then rotates the cell ring once past the compare head,
// then commits the write and the result; a new word is taken only in idle.
// The ring makes a single full rotation per word.
// Reset (synchronous, active low) clears the count, the FSM and the output valid;
// entries stay undefined and are never read before written.
// A result waiting on i_ready holds the unit in commit; the next word is taken
// as soon as the commit is done, while the result still sits in the output.
module bounded_set_table_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [bst_pkg::CMD_W-1:0]    i_command,
    input  wire  signed [bst_pkg::VAL_W-1:0] i_value,
    input  wire  [bst_pkg::RIX_W-1:0]    i_index,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic                         o_success,
    output logic signed [bst_pkg::VAL_W-1:0] o_read_value,
    output logic                         o_index_error,
    output logic [bst_pkg::CNT_W-1:0]    o_entry_count,
    input  wire                          i_cfg_we,
    input  wire  [bst_pkg::CAP_W-1:0]    i_cfg_data
);
    import bst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state              r_state;
    logic [CAP_W-1:0]    r_capacity;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_pos;

    // latched word
    t_cmd                r_cmd;
    logic [VAL_W-1:0]    r_value;
    logic [RIX_W-1:0]    r_index;

    // scan results
    logic                r_found;
    logic [IDX_W-1:0]    r_slot;
    logic [VAL_W-1:0]    r_last;
    logic [VAL_W-1:0]    r_rd;

    // output register
    logic                r_out_valid;
    logic                r_out_success;
    logic [VAL_W-1:0]    r_out_rd;
    logic                r_out_ierr;

    t_cell_ctl           w_ctl;
    logic [IDX_W-1:0]    w_wr_idx;
    logic [VAL_W-1:0]    w_wr_data;
    logic                w_do_write;
    logic [VAL_W-1:0]    w_cell_data [DEPTH];

    logic                w_accept;
    logic                w_out_free;
    logic                w_commit;
    logic                w_live;
    logic                w_ins_ok;
    logic                w_rd_ok;
    logic                w_ok;

    logic [VAL_W-1:0]    w_head;

    assign w_head     = w_cell_data[0];
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_commit   = (r_state == S_COMMIT) && w_out_free;

    // head entry is live while its position is below the count
    assign w_live   = 32'(r_pos) < 32'(r_count);
    // effective capacity is min(limit, DEPTH); count below it also keeps the slot in range
    assign w_ins_ok = !r_found && (32'(r_count) < 32'(r_capacity))
                      && (32'(r_count) < DEPTH);
    assign w_rd_ok  = 32'(r_index) < 32'(r_count);

    always_comb begin
        w_ok       = 1'b0;
        w_do_write = 1'b0;
        w_wr_idx   = r_slot;
        w_wr_data  = r_last;
        case (r_cmd)
            CMD_INSERT: begin
                w_ok       = w_ins_ok;
                w_do_write = w_ins_ok;
                w_wr_idx   = r_count[IDX_W-1:0];
                w_wr_data  = r_value;
            end
            CMD_REMOVE: begin
                // last live entry moves into the freed slot
                w_ok       = r_found;
                w_do_write = r_found;
            end
            CMD_MEMBER: begin
                w_ok = r_found;
            end
            CMD_READ: begin
                w_ok = w_rd_ok;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    assign w_ctl.shift = (r_state == S_SCAN);
    assign w_ctl.wr_en = w_commit && w_do_write;

    // ring of cells: cell k takes cell k+1, the last wraps to cell 0
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam int NXT = (k + 1) % DEPTH;
        bst_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_sel       (w_wr_idx == IDX_W'(k)),
            .i_wr_data   (w_wr_data),
            .i_next_data (w_cell_data[NXT]),
            .o_data      (w_cell_data[k])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            // a commit refills the output in the cycle the old word leaves
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                        r_pos   <= '0;
                    end
                end
                S_SCAN: begin
                    r_pos <= IDX_W'(r_pos + 1'b1);
                    if (32'(r_pos) == DEPTH - 1) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (r_cmd == CMD_INSERT && w_ok) begin
                            r_count <= CNT_W'(r_count + 1'b1);
                        end else if (r_cmd == CMD_REMOVE && w_ok) begin
                            r_count <= CNT_W'(r_count - 1'b1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // word and scan payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_command);
            r_value <= i_value;
            r_index <= i_index;
            r_found <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (w_live && w_head == r_value) begin
                r_found <= 1'b1;
                r_slot  <= r_pos;
            end
            if (32'(r_pos) + 1 == 32'(r_count)) begin
                r_last <= w_head;
            end
            if (32'(r_pos) == 32'(r_index)) begin
                r_rd <= w_head;
            end
        end
        if (w_commit) begin
            r_out_success <= w_ok;
            r_out_rd      <= (r_cmd == CMD_READ && w_rd_ok) ? r_rd : '0;
            r_out_ierr    <= (r_cmd == CMD_READ) && !w_rd_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_success     = r_out_success;
    assign o_read_value  = r_out_rd;
    assign o_index_error = r_out_ierr;
    assign o_entry_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("live count above table depth");

    a_commit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) && r_out_valid && !i_ready |=> (r_state == S_COMMIT))
        else $error("commit overwrote an untaken result");

    a_count_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && ($past(r_state) != S_COMMIT) |-> $stable(r_count))
        else $error("count moved outside commit");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_success && r_out_ierr))
        else $error("success and index error both set");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN) && (r_pos == '0))
        else $error("accepted word did not start a scan");

endmodule
`default_nettype wire

/* rtl/core/bst_cell.sv */
`default_nettype none
module bst_cell (
    input  wire                          i_clk,
    input  wire bst_pkg::t_cell_ctl      i_ctl,
    input  wire                          i_sel,
    input  wire  [bst_pkg::VAL_W-1:0]    i_wr_data,
    input  wire  [bst_pkg::VAL_W-1:0]    i_next_data,
    output logic [bst_pkg::VAL_W-1:0]    o_data
);
    import bst_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    // Rotation takes the neighbor's entry; a write lands only when not rotating
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_next_data;
        end else if (i_ctl.wr_en && i_sel) begin
            n_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire
